// ----- src/sfclh_pkg.sv -----
// Shared constants, types and helper functions of the cycle loss histogram.
package sfclh_pkg;

   // Histogram geometry
   localparam int RSSI_BINS = 64;
   localparam int SF_COUNT  = 6;
   localparam int SF_BASE   = 7;
   localparam int CELLS     = SF_COUNT * RSSI_BINS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int ROW_W     = (SF_COUNT > 1) ? $clog2(SF_COUNT) : 1;
   localparam int COL_W     = $clog2(RSSI_BINS);

   // Field widths
   localparam int SF_W     = 4;
   localparam int RSSI_W   = 9;
   localparam int OFF_W    = 8;
   localparam int RD_ROW_W = 3;
   localparam int RD_COL_W = 6;
   localparam int CNT_W    = 32;

   // Arithmetic widths: signed bin column, RSSI difference, divisor, numerator
   localparam int BIN_W  = 11;
   localparam int DIFF_W = 11;
   localparam int D_W    = $clog2(SF_COUNT + 1);
   localparam int MAG_W  = 11 + $clog2(SF_COUNT);
   localparam int NUM_W  = MAG_W + 1;

   // Register interface
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic [PADDR_W-3:0] REG_RSSI_OFFSET = '0;

   // Request codes
   localparam logic REQ_PACKET = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CUR,
      ST_RD,
      ST_WR,
      ST_SETUP,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_NEXT,
      ST_RRD,
      ST_RRESP
   } state_type;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] dividend;
      logic [D_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] quotient;
   } div_rsp_type;

   // Saturating counter increment
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == '1) ? v : v + CNT_W'(1);
   endfunction

   // Flat cell address of a (row, column) pair
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      cell_addr = ADDR_W'(row) * ADDR_W'(RSSI_BINS) + ADDR_W'(col);
   endfunction

endpackage

// ----- src/sfclh_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module sfclh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/sfclh_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned magnitude by small divisor.
module sfclh_div (
   input  logic                   clock,
   input  logic                   reset,
   input  sfclh_pkg::div_req_type div_req,
   output sfclh_pkg::div_rsp_type div_rsp
);
   import sfclh_pkg::*;

   localparam int STEP_W = (MAG_W > 1) ? $clog2(MAG_W) : 1;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [D_W-1:0]    rem_ff, rem_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [D_W-1:0]    dvs_ff, dvs_in;

   logic [D_W:0]      trial;
   logic              fits;

   // Trial subtract of the shifted partial remainder
   always_comb begin
      trial = {rem_ff, quo_ff[MAG_W-1]};
      fits  = trial >= {1'b0, dvs_ff};
   end

   // Load on start, then shift one dividend bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? D_W'(trial - {1'b0, dvs_ff}) : D_W'(trial);
         quo_in  = {quo_ff[MAG_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- src/sf_cycle_loss_histogram_core.sv -----
// Spreading-factor cycle loss histogram: sequencer, counter memory and register port.
// Read request: memory read in ST_RRD, result registered in ST_RRESP, then back to idle.
// Packet: bin check in ST_CUR (then idle for an invalid SF), received-bin read-modify-write,
//   then per lost packet the 14-step shared divider and a read-modify-write; up to 5 lost.
// Synchronous active-high reset; afterwards a clearing pass over all 384 cells zeroes the
//   counter memory while req_ready stays low. Register writes are taken at any time.
module sf_cycle_loss_histogram_core (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [sfclh_pkg::SF_W-1:0]      req_spreading_factor,
   input  logic signed [sfclh_pkg::RSSI_W-1:0] req_rssi_dbm,
   input  logic [sfclh_pkg::RD_ROW_W-1:0]  req_read_sf_index,
   input  logic [sfclh_pkg::RD_COL_W-1:0]  req_read_rssi_bin,
   // Response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sfclh_pkg::CNT_W-1:0]     rsp_error_count,
   output logic [sfclh_pkg::CNT_W-1:0]     rsp_total_count,
   // Register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sfclh_pkg::PADDR_W-1:0]   paddr,
   input  logic [sfclh_pkg::PDATA_W-1:0]   pwdata,
   output logic [sfclh_pkg::PDATA_W-1:0]   prdata,
   output logic                            pready
);
   import sfclh_pkg::*;

   localparam logic signed [BIN_W-1:0] BINS_S   = BIN_W'(RSSI_BINS);
   localparam logic signed [NUM_W-1:0] BINS_N   = NUM_W'(RSSI_BINS);
   localparam int                      RCHK_W   = RD_COL_W + 3;
   localparam int                      WORD_W   = 2 * CNT_W;

   state_type state_ff, state_in;

   // Item and previous-packet state
   logic [SF_W-1:0]          sf_ff, sf_in;
   logic signed [RSSI_W-1:0] rssi_ff, rssi_in;
   logic [OFF_W-1:0]         off_ff, off_in;
   logic                     have_prev_ff, have_prev_in;
   logic [SF_W-1:0]          prev_sf_ff, prev_sf_in;
   logic signed [RSSI_W-1:0] prev_rssi_ff, prev_rssi_in;

   // Working registers
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic                     lost_ff, lost_in;
   logic                     rd_ok_ff, rd_ok_in;
   logic signed [NUM_W-1:0]  num_ff, num_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [D_W-1:0]           d_ff, d_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [D_W-1:0]           left_ff, left_in;

   // Response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]         rsp_err_ff, rsp_err_in;
   logic [CNT_W-1:0]         rsp_tot_ff, rsp_tot_in;

   // Memory and divider ports
   logic                     ram_we;
   logic [ADDR_W-1:0]        ram_waddr;
   logic [WORD_W-1:0]        ram_wdata;
   logic [WORD_W-1:0]        ram_rdata;
   logic [CNT_W-1:0]         rd_err, rd_tot;
   div_req_type              div_req;
   div_rsp_type              div_rsp;

   // Datapath helpers
   logic                     sf_ok;
   logic [ROW_W-1:0]         cur_row;
   logic signed [BIN_W-1:0]  cur_col;
   logic                     cur_col_ok;
   logic [SF_W:0]            miss_wide;
   logic [D_W-1:0]           miss;
   logic [D_W-1:0]           d_val;
   logic signed [BIN_W-1:0]  prev_p;
   logic signed [DIFF_W-1:0] diff_val;
   logic signed [NUM_W-1:0]  num_init;
   logic [ROW_W-1:0]         prev_row;
   logic [ROW_W-1:0]         row_start;
   logic                     num_neg;
   logic signed [NUM_W-1:0]  num_abs;
   logic signed [NUM_W-1:0]  quo_u;
   logic signed [NUM_W-1:0]  quo_s;
   logic                     lost_col_ok;
   logic                     rd_in_range;
   logic                     csr_wr;

   // Current packet bin
   always_comb begin
      sf_ok      = (sf_ff >= SF_W'(SF_BASE)) && (sf_ff < SF_W'(SF_BASE + SF_COUNT));
      cur_row    = ROW_W'(sf_ff - SF_W'(SF_BASE));
      cur_col    = BIN_W'(rssi_ff) + BIN_W'($signed({1'b0, off_ff}));
      cur_col_ok = (cur_col >= 0) && (cur_col < BINS_S);
   end

   // Lost-packet count and interpolation start
   always_comb begin
      if (sf_ff > prev_sf_ff) begin
         miss_wide = {1'b0, sf_ff} - {1'b0, prev_sf_ff} - (SF_W+1)'(1);
      end else begin
         miss_wide = {1'b0, sf_ff} + (SF_W+1)'(SF_COUNT) - {1'b0, prev_sf_ff}
                     - (SF_W+1)'(1);
      end
      miss      = D_W'(miss_wide);
      d_val     = miss + D_W'(1);
      prev_p    = BIN_W'(prev_rssi_ff) + BIN_W'($signed({1'b0, off_ff}));
      diff_val  = DIFF_W'(rssi_ff) - DIFF_W'(prev_rssi_ff);
      num_init  = NUM_W'(prev_p) * NUM_W'($signed({1'b0, d_val})) + NUM_W'(diff_val);
      prev_row  = ROW_W'(prev_sf_ff - SF_W'(SF_BASE));
      row_start = (prev_row == ROW_W'(SF_COUNT - 1)) ? '0 : prev_row + ROW_W'(1);
   end

   // Sign handling around the magnitude divider
   always_comb begin
      num_neg     = num_ff[NUM_W-1];
      num_abs     = num_neg ? -num_ff : num_ff;
      quo_u       = $signed(NUM_W'(div_rsp.quotient));
      quo_s       = num_neg ? -quo_u : quo_u;
      lost_col_ok = (quo_s >= 0) && (quo_s < BINS_N);
   end

   // Read request range check
   always_comb begin
      rd_in_range = ({1'b0, req_read_sf_index} < (RD_ROW_W+1)'(SF_COUNT))
                    && (RCHK_W'(req_read_rssi_bin) < RCHK_W'(RSSI_BINS));
   end

   assign div_req.start    = (state_ff == ST_DIV_GO);
   assign div_req.dividend = MAG_W'(num_abs);
   assign div_req.divisor  = d_ff;

   assign rd_err = ram_rdata[WORD_W-1:CNT_W];
   assign rd_tot = ram_rdata[CNT_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_type == REQ_READ) ? ST_RRD : ST_CUR;
            end
         end
         ST_CUR: begin
            if (!sf_ok) begin
               state_in = ST_IDLE;
            end else if (cur_col_ok) begin
               state_in = ST_RD;
            end else begin
               state_in = ST_SETUP;
            end
         end
         ST_RD: begin
            state_in = ST_WR;
         end
         ST_WR: begin
            state_in = lost_ff ? ST_NEXT : ST_SETUP;
         end
         ST_SETUP: begin
            state_in = (have_prev_ff && (miss != '0)) ? ST_DIV_GO : ST_IDLE;
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = lost_col_ok ? ST_RD : ST_NEXT;
            end
         end
         ST_NEXT: begin
            state_in = (left_ff == D_W'(1)) ? ST_IDLE : ST_DIV_GO;
         end
         ST_RRD: begin
            state_in = ST_RRESP;
         end
         ST_RRESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs and datapath updates
   always_comb begin
      req_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;
      sf_in        = sf_ff;
      rssi_in      = rssi_ff;
      have_prev_in = have_prev_ff;
      prev_sf_in   = prev_sf_ff;
      prev_rssi_in = prev_rssi_ff;
      addr_in      = addr_ff;
      lost_in      = lost_ff;
      rd_ok_in     = rd_ok_ff;
      num_in       = num_ff;
      diff_in      = diff_ff;
      d_in         = d_ff;
      row_in       = row_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_err_in   = rsp_err_ff;
      rsp_tot_in   = rsp_tot_ff;
      case (state_ff)
         ST_CLEAR: begin
            // sweep the memory with zeros
            ram_we  = 1'b1;
            addr_in = (addr_ff == ADDR_W'(CELLS - 1)) ? '0 : addr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               sf_in    = req_spreading_factor;
               rssi_in  = req_rssi_dbm;
               rd_ok_in = rd_in_range;
               if (req_type == REQ_READ) begin
                  addr_in = cell_addr(ROW_W'(req_read_sf_index), COL_W'(req_read_rssi_bin));
               end
            end
         end
         ST_CUR: begin
            lost_in = 1'b0;
            if (sf_ok && cur_col_ok) begin
               addr_in = cell_addr(cur_row, COL_W'(cur_col));
            end
         end
         ST_WR: begin
            // saturating increment of total, and of error for a lost packet
            ram_we = 1'b1;
            if (lost_ff) begin
               ram_wdata = {sat_inc(rd_err), sat_inc(rd_tot)};
            end else begin
               ram_wdata = {rd_err, sat_inc(rd_tot)};
            end
         end
         ST_SETUP: begin
            have_prev_in = 1'b1;
            prev_sf_in   = sf_ff;
            prev_rssi_in = rssi_ff;
            num_in       = num_init;
            diff_in      = diff_val;
            d_in         = d_val;
            row_in       = row_start;
            left_in      = miss;
         end
         ST_DIV_WAIT: begin
            lost_in = 1'b1;
            if (div_rsp.done && lost_col_ok) begin
               addr_in = cell_addr(row_ff, COL_W'(quo_s));
            end
         end
         ST_NEXT: begin
            // advance to the next lost packet
            left_in = left_ff - D_W'(1);
            num_in  = num_ff + NUM_W'(diff_ff);
            row_in  = (row_ff == ROW_W'(SF_COUNT - 1)) ? '0 : row_ff + ROW_W'(1);
         end
         ST_RRESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = rd_ok_ff ? rd_err : '0;
               rsp_tot_in   = rd_ok_ff ? rd_tot : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready
                   && (paddr[PADDR_W-1:2] == REG_RSSI_OFFSET);
   assign off_in = csr_wr ? pwdata[OFF_W-1:0] : off_ff;
   assign prdata = (paddr[PADDR_W-1:2] == REG_RSSI_OFFSET) ? PDATA_W'(off_ff) : '0;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         have_prev_ff <= 1'b0;
         prev_sf_ff   <= '0;
         prev_rssi_ff <= '0;
         off_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         have_prev_ff <= have_prev_in;
         prev_sf_ff   <= prev_sf_in;
         prev_rssi_ff <= prev_rssi_in;
         off_ff       <= off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sf_ff      <= sf_in;
      rssi_ff    <= rssi_in;
      lost_ff    <= lost_in;
      rd_ok_ff   <= rd_ok_in;
      num_ff     <= num_in;
      diff_ff    <= diff_in;
      d_ff       <= d_in;
      row_ff     <= row_in;
      left_ff    <= left_in;
      rsp_err_ff <= rsp_err_in;
      rsp_tot_ff <= rsp_tot_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_error_count = rsp_err_ff;
   assign rsp_total_count = rsp_tot_ff;

   // Counter memory: error count in the upper half, total count in the lower half
   sfclh_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CELLS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   // Shared divider for the interpolated bin column
   sfclh_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule
